>>> src/kls_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and handshake structs of the keyframe linear sampler.
package kls_pkg;

   localparam int KEYS       = 64;
   localparam int IDX_W      = $clog2(KEYS);
   localparam int CNT_W      = $clog2(KEYS + 1);
   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 17;
   localparam int DCNT_W     = $clog2(FRAC_W);
   localparam int DIFF_W     = DATA_W + 1;
   localparam int PROD_W     = DIFF_W + FRAC_W + 1;
   localparam int ROUND_BIAS = 32768;
   localparam int FRAC_SHIFT = 16;
   localparam int OUT_KEYS_W = 7;
   localparam int REQ_DATA_W = 4 * DATA_W;
   localparam int RSP_DATA_W = ((3 * DATA_W + OUT_KEYS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - 3 * DATA_W - OUT_KEYS_W;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_SAMPLE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_FIRST,
      S_SCAN,
      S_DIV,
      S_DIFF,
      S_MUL,
      S_ACC,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_ONE,
      RD_NEXT
   } rd_src_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_ZERO,
      RES_RDATA,
      RES_PREV,
      RES_LANE
   } res_sel_type;

   typedef struct packed {
      logic [DATA_W-1:0] t;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] z;
   } key_type;

   typedef struct packed {
      logic        ready;
      logic        item_load;
      logic        clear;
      logic        append;
      rd_src_type  rd_src;
      res_sel_type res_sel;
      status_type  status;
      logic        first_load;
      logic        scan_step;
      logic        div_start;
      logic        div_step;
      logic        diff;
      logic        mul;
      logic        acc;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     count_zero;
      logic     count_one;
      logic     full;
      logic     t_le_rd;
      logic     found;
      logic     span_zero;
      logic     scan_last;
      logic     div_done;
      logic     lane_last;
      logic     out_free;
   } stat_type;

endpackage

>>> src/keyframe_linear_sampler.sv
`timescale 1ns / 1ps
// Top level of the keyframe linear sampler: controller plus datapath.
//
// Holds up to 64 keyframes (time, x, y, z) in one 128-bit wide memory with one
// write and one read port, appended in order of arrival, and answers every
// request word with exactly one result word. Mode 0 clears the table, mode 1
// appends a key (status 2 and the key dropped when the table is full), mode 2
// samples at key_time: status 1 on an empty table, the first value at or
// before the first key, the last value past the last key, and otherwise a
// linear blend of the first bracketing pair of adjacent keys, rounded to
// nearest with ties upward. Values are zero unless a sample succeeds. Items
// are handled one at a time. A sample reads one memory entry per cycle while
// it walks adjacent pairs, and a true interpolation then runs the bit-serial
// fraction divider and three passes through the shared 33x18 multiplier.
// The next word is accepted while a finished result still waits in the
// output register; reset leaves the table empty.
module keyframe_linear_sampler
   import kls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] key_time, [63:32] value_x, [95:64] value_y, [127:96] value_z
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] out_x, [63:32] out_y, [95:64] out_z, [102:96] stored_keys, [103] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]            rsp_tuser
);

   cmd_type  cmd;
   stat_type stat;

   kls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .stat       (stat),
      .cmd        (cmd)
   );

   kls_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Ready only while the controller waits for a new word.
   assign req_tready = cmd.ready;

endmodule

>>> src/kls_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the keyframe linear sampler.
module kls_ctrl
   import kls_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.mode == MODE_SAMPLE && !stat.count_zero) begin
               state_in = S_FIRST;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FIRST: begin
            if (stat.count_one || stat.t_le_rd) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.found) begin
               state_in = stat.span_zero ? S_FINISH : S_DIV;
            end else if (stat.scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: state_in = S_MUL;
         S_MUL:  state_in = S_ACC;
         S_ACC: begin
            state_in = stat.lane_last ? S_FINISH : S_DIFF;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rd_src  = RD_ZERO;
      cmd.res_sel = RES_HOLD;
      cmd.status  = STATUS_OK;
      case (state_ff)
         S_IDLE: begin
            cmd.ready     = 1'b1;
            cmd.item_load = req_tvalid;
         end
         S_DECODE: begin
            cmd.res_sel = RES_ZERO;
            cmd.clear   = (stat.mode == MODE_CLEAR);
            cmd.append  = (stat.mode == MODE_APPEND) && !stat.full;
            if (stat.mode == MODE_APPEND && stat.full) begin
               cmd.status = STATUS_FULL;
            end else if (stat.mode == MODE_SAMPLE && stat.count_zero) begin
               cmd.status = STATUS_EMPTY;
            end
         end
         S_FIRST: begin
            cmd.first_load = 1'b1;
            cmd.rd_src     = RD_ONE;
            if (stat.count_one || stat.t_le_rd) begin
               cmd.res_sel = RES_RDATA;
            end
         end
         S_SCAN: begin
            cmd.rd_src = RD_NEXT;
            if (stat.found) begin
               if (stat.span_zero) begin
                  cmd.res_sel = RES_PREV;
               end else begin
                  cmd.div_start = 1'b1;
               end
            end else begin
               cmd.scan_step = 1'b1;
               if (stat.scan_last) begin
                  cmd.res_sel = RES_RDATA;
               end
            end
         end
         S_DIV:  cmd.div_step = 1'b1;
         S_DIFF: cmd.diff     = 1'b1;
         S_MUL:  cmd.mul      = 1'b1;
         S_ACC: begin
            cmd.acc     = 1'b1;
            cmd.res_sel = RES_LANE;
         end
         S_FINISH: cmd.out_load = stat.out_free;
         default: ;
      endcase
   end

endmodule

>>> src/kls_datapath.sv
`timescale 1ns / 1ps
// Datapath of the keyframe linear sampler: key memory, scan, divider, multiplier, output word.
module kls_datapath
   import kls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tready,
   output stat_type              stat,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser
);

   key_type key_mem [KEYS];

   mode_type          mode_ff;
   logic [DATA_W-1:0] time_ff;
   key_type           wr_key_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  rd_addr;
   key_type           rd_q_ff;
   key_type           prev_ff;
   key_type           next_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] span_ff;
   logic [FRAC_W-1:0] quo_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [DATA_W:0]   trial;
   logic              trial_ge;

   logic [1:0]               lane_ff;
   logic [DATA_W-1:0]        lane_a;
   logic [DATA_W-1:0]        lane_b;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] round_sum;
   logic [DATA_W-1:0]        lane_val;

   logic [DATA_W-1:0] res_x_ff, res_y_ff, res_z_ff;
   status_type        res_status_ff;

   logic                  rsp_tvalid_ff;
   logic [DATA_W-1:0]     out_x_ff, out_y_ff, out_z_ff;
   status_type            out_status_ff;
   logic [OUT_KEYS_W-1:0] out_keys_ff;
   logic                  out_free;

   // Item registers.
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         mode_ff     <= mode_type'(req_tuser);
         time_ff     <= req_tdata[DATA_W-1:0];
         wr_key_ff.t <= req_tdata[DATA_W-1:0];
         wr_key_ff.x <= req_tdata[2*DATA_W-1:DATA_W];
         wr_key_ff.y <= req_tdata[3*DATA_W-1:2*DATA_W];
         wr_key_ff.z <= req_tdata[4*DATA_W-1:3*DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.append) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      case (cmd.rd_src)
         RD_ZERO: rd_addr = '0;
         RD_ONE:  rd_addr = IDX_W'(1);
         RD_NEXT: rd_addr = idx_ff + IDX_W'(2);
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         key_mem[count_ff[IDX_W-1:0]] <= wr_key_ff;
      end
      rd_q_ff <= key_mem[rd_addr];
   end

   // Scan over adjacent pairs: prev holds entry idx, the read word entry idx+1.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.first_load) begin
         idx_ff <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.first_load || cmd.scan_step) begin
         prev_ff <= rd_q_ff;
      end
      if (cmd.div_start) begin
         next_ff <= rd_q_ff;
      end
   end

   // Restoring divider, one quotient bit a cycle, most significant first.
   assign trial    = (dcnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign trial_ge = trial >= {1'b0, span_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff  <= time_ff - prev_ff.t;
         span_ff <= rd_q_ff.t - prev_ff.t;
         quo_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= trial_ge ? DATA_W'(trial - {1'b0, span_ff}) : DATA_W'(trial);
         quo_ff  <= {quo_ff[FRAC_W-2:0], trial_ge};
      end
   end

   // One shared multiplier, one component at a time.
   always_comb begin
      case (lane_ff)
         2'd0: begin
            lane_a = prev_ff.x;
            lane_b = next_ff.x;
         end
         2'd1: begin
            lane_a = prev_ff.y;
            lane_b = next_ff.y;
         end
         default: begin
            lane_a = prev_ff.z;
            lane_b = next_ff.z;
         end
      endcase
   end

   assign round_sum = prod_ff + PROD_W'(ROUND_BIAS);
   assign lane_val  = lane_a + round_sum[FRAC_SHIFT +: DATA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else if (cmd.div_start) begin
         lane_ff <= '0;
      end else if (cmd.acc) begin
         lane_ff <= lane_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         diff_ff <= $signed({lane_b[DATA_W-1], lane_b}) - $signed({lane_a[DATA_W-1], lane_a});
      end
      if (cmd.mul) begin
         prod_ff <= diff_ff * $signed({1'b0, quo_ff});
      end
   end

   // Result staging.
   always_ff @(posedge clock) begin
      case (cmd.res_sel)
         RES_ZERO: begin
            res_x_ff      <= '0;
            res_y_ff      <= '0;
            res_z_ff      <= '0;
            res_status_ff <= cmd.status;
         end
         RES_RDATA: begin
            res_x_ff <= rd_q_ff.x;
            res_y_ff <= rd_q_ff.y;
            res_z_ff <= rd_q_ff.z;
         end
         RES_PREV: begin
            res_x_ff <= prev_ff.x;
            res_y_ff <= prev_ff.y;
            res_z_ff <= prev_ff.z;
         end
         RES_LANE: begin
            case (lane_ff)
               2'd0:    res_x_ff <= lane_val;
               2'd1:    res_y_ff <= lane_val;
               default: res_z_ff <= lane_val;
            endcase
         end
         default: ;
      endcase
   end

   // Output word register.
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_x_ff      <= res_x_ff;
         out_y_ff      <= res_y_ff;
         out_z_ff      <= res_z_ff;
         out_status_ff <= res_status_ff;
         out_keys_ff   <= OUT_KEYS_W'(count_ff);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_keys_ff, out_z_ff, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_status_ff;

   always_comb begin
      stat.mode       = mode_ff;
      stat.count_zero = (count_ff == '0);
      stat.count_one  = (count_ff == CNT_W'(1));
      stat.full       = (count_ff == CNT_W'(KEYS));
      stat.t_le_rd    = (time_ff <= rd_q_ff.t);
      stat.found      = (prev_ff.t <= time_ff) && (time_ff <= rd_q_ff.t);
      stat.span_zero  = (rd_q_ff.t == prev_ff.t);
      stat.scan_last  = (({1'b0, idx_ff} + CNT_W'(2)) == count_ff);
      stat.div_done   = (dcnt_ff == DCNT_W'(FRAC_W - 1));
      stat.lane_last  = (lane_ff == 2'd2);
      stat.out_free   = out_free;
   end

endmodule

>>> src/kls_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the keyframe linear sampler and its bind.
module kls_checker
   import kls_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   logic [OUT_KEYS_W-1:0] keys;
   assign keys = rsp_tdata[3*DATA_W +: OUT_KEYS_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is still at work");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata[3*DATA_W-1:0] == '0)
      else $error("error result carries a value");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL |-> keys == OUT_KEYS_W'(KEYS))
      else $error("full status with table not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |-> keys == '0)
      else $error("empty status with keys held");

endmodule

bind keyframe_linear_sampler kls_checker u_kls_checker (.*);
